// ----- design/trapezoidal_trajectory_step_top_defines.svh -----
// Assertion macros shared by the trapezoidal trajectory step block.
`ifndef TRAPEZOIDAL_TRAJECTORY_STEP_TOP_DEFINES_SVH
`define TRAPEZOIDAL_TRAJECTORY_STEP_TOP_DEFINES_SVH
// Same-cycle implication, checked outside of reset.
`define RTTS_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("rtts check failed");
// Next-cycle implication, checked outside of reset.
`define RTTS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("rtts check failed");
`endif

// ----- design/rtts_pkg.sv -----
// Package with types and constants of the trapezoidal trajectory step block.
`timescale 1ns / 1ps
package rtts_pkg;
    localparam int W_VAL = 32;
    localparam int W_LIM = 31;
    localparam int W_DT  = 24;
    localparam int W_CNT = 5;

    localparam logic [W_DT-1:0] DT_MAX     = 24'd8388608;
    localparam logic [W_DT-1:0] DT_DEFAULT = 24'd16777;

    localparam logic CFG_SPEED = 1'b0;
    localparam logic CFG_ACCEL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_MUL1, ST_PICK, ST_STEP, ST_MUL2, ST_LAND, ST_OUT
    } t_state;

    typedef struct packed {
        logic              restart;
        logic [W_VAL-1:0]  mvel;
        logic [W_VAL-1:0]  mpos;
        logic [W_DT-1:0]   dt;
        logic [W_VAL-1:0]  goal;
    } t_item;

    typedef struct packed {
        logic [W_LIM-1:0] speed;
        logic [W_LIM-1:0] accel;
    } t_cfg;

    typedef struct packed {
        logic [W_VAL-1:0] acc;
        logic [W_VAL-1:0] vel;
        logic [W_VAL-1:0] pos;
    } t_result;
endpackage

// ----- design/rtts_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module rtts_mul
    import rtts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [W_VAL-1:0]   i_mcand,
    input  logic [W_VAL-1:0]   i_mplier,
    output logic [2*W_VAL-1:0] o_prod,
    output logic               o_done
);
    logic [W_VAL-1:0] r_mcand;
    logic [W_VAL-1:0] r_hi;
    logic [W_VAL-1:0] r_lo;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W_VAL:0]   w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(W_VAL+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {W_CNT{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The partial sum shifts right one place a cycle; after all steps the
    // product sits in the high and low halves.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= w_sum[W_VAL:1];
            r_lo <= {w_sum[0], r_lo[W_VAL-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};
    assign o_done = r_done;
endmodule

// ----- design/rtts_core.sv -----
// Step sequencer and profile state of the trapezoidal trajectory block.
`timescale 1ns / 1ps
module rtts_core
    import rtts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_start,
    input  t_item   i_item,
    output logic    o_idle,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);
    t_state r_state, n_state;
    logic             r_seeded, n_seeded;
    logic [W_VAL-1:0] r_pos, n_pos, r_vel, n_vel, r_acc, n_acc, r_goal, n_goal;
    logic [W_VAL-1:0] r_dist, n_dist, r_speed, n_speed;
    logic [W_DT-1:0]  r_dt, n_dt;
    logic             r_dpos, n_dpos, r_dneg, n_dneg;

    logic [2*W_VAL-1:0] w_p0, w_p1, w_p2;
    logic               w_d0, w_d1, w_d2;
    logic               w_st0, w_st1;
    logic [W_VAL-1:0]   w_m0a, w_m0b;
    logic               w_aon;

    logic [W_VAL:0]     w_err;
    logic [W_VAL:0]     w_errmag;
    logic [W_VAL-1:0]   w_spd;
    logic [W_VAL-1:0]   w_vmag;
    logic               w_almost, w_alneg, w_stop, w_below, w_tow, w_away;
    logic               w_apos, w_aneg;
    logic [W_VAL+1:0]   w_dv, w_v, w_vlim;
    logic [W_VAL-1:0]   w_smag;
    logic [W_VAL+1:0]   w_p;
    logic [W_VAL+1:0]   w_pmax, w_pmin;
    logic [W_DT-1:0]    w_dtin;

    assign w_aon = (i_cfg.accel != '0);
    assign w_err = {r_goal[W_VAL-1], r_goal} - {r_pos[W_VAL-1], r_pos};
    assign w_errmag = w_err[W_VAL] ? (~w_err + 1'b1) : w_err;
    assign w_spd  = r_vel[W_VAL-1] ? (~r_vel + 1'b1) : r_vel;
    assign w_vmag = w_spd;

    assign w_st0 = ((r_state == ST_SETUP) && w_aon) || (r_state == ST_STEP);
    assign w_st1 = (r_state == ST_SETUP) && w_aon;
    assign w_m0a = (r_state == ST_SETUP) ? w_spd : w_vmag;
    assign w_m0b = (r_state == ST_SETUP) ? w_spd : {{(W_VAL-W_DT){1'b0}}, r_dt};

    rtts_mul u_mul0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_st0),
        .i_mcand(w_m0a), .i_mplier(w_m0b), .o_prod(w_p0), .o_done(w_d0));
    rtts_mul u_mul1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_st1),
        .i_mcand(w_errmag[W_VAL-1:0]), .i_mplier({i_cfg.accel, 1'b0}),
        .o_prod(w_p1), .o_done(w_d1));
    rtts_mul u_mul2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_st1),
        .i_mcand({1'b0, i_cfg.accel}), .i_mplier({{(W_VAL-W_DT){1'b0}}, r_dt}),
        .o_prod(w_p2), .o_done(w_d2));

    // Stop test: floor(v^2 / 2a) >= d exactly when v^2 >= 2a * d.
    assign w_almost = (r_dist == '0) &&
                      ({{(2*W_VAL-W_VAL-W_DT){1'b0}}, r_speed, {W_DT{1'b0}}} < w_p2);
    assign w_alneg  = (r_dpos && r_vel[W_VAL-1]) ||
                      (r_dneg && !r_vel[W_VAL-1] && (r_vel != '0));
    assign w_stop   = (w_p0 >= w_p1);
    assign w_below  = (r_speed < {1'b0, i_cfg.speed});
    assign w_tow    = w_alneg || (!w_stop && w_below);
    assign w_away   = !w_alneg && w_stop;
    assign w_apos   = (r_dpos && w_tow) || (r_dneg && w_away);
    assign w_aneg   = (r_dneg && w_tow) || (r_dpos && w_away);
    assign w_dv     = w_apos ? {3'b000, w_p2[W_DT+W_LIM-1:W_DT]} :
                      w_aneg ? (~{3'b000, w_p2[W_DT+W_LIM-1:W_DT]} + 1'b1) : '0;
    assign w_v      = {{2{r_vel[W_VAL-1]}}, r_vel} + w_dv;
    assign w_vlim   = {3'b000, i_cfg.speed};

    assign w_smag = w_p0[W_DT+W_VAL-1:W_DT];
    assign w_p    = r_vel[W_VAL-1] ? ({{2{r_pos[W_VAL-1]}}, r_pos} - {2'b00, w_smag}) :
                                     ({{2{r_pos[W_VAL-1]}}, r_pos} + {2'b00, w_smag});
    assign w_pmax = {3'b000, {(W_VAL-1){1'b1}}};
    assign w_pmin = {3'b111, {(W_VAL-1){1'b0}}};

    assign w_dtin = ((i_item.dt == '0) || (i_item.dt > DT_MAX)) ? DT_DEFAULT : i_item.dt;

    always_comb begin
        n_state  = r_state;
        n_seeded = r_seeded;
        n_pos = r_pos;  n_vel = r_vel;  n_acc = r_acc;  n_goal = r_goal;
        n_dist = r_dist;  n_speed = r_speed;  n_dt = r_dt;
        n_dpos = r_dpos;  n_dneg = r_dneg;
        o_idle = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    if (!r_seeded || i_item.restart) begin
                        n_pos = i_item.mpos;
                        n_vel = i_item.mvel;
                        n_seeded = 1'b1;
                    end
                    n_goal  = i_item.goal;
                    n_dt    = w_dtin;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_acc = '0;
                if (!w_aon) begin
                    n_pos = r_goal;
                    n_vel = '0;
                    n_state = ST_OUT;
                end else begin
                    n_dist  = w_errmag[W_VAL-1:0];
                    n_speed = w_spd;
                    n_dpos  = !w_err[W_VAL] && (w_err != '0);
                    n_dneg  = w_err[W_VAL];
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (w_d0 && w_d1 && w_d2) n_state = ST_PICK;
            end
            ST_PICK: begin
                if (w_almost) begin
                    n_pos = r_goal;
                    n_vel = '0;
                    n_state = ST_OUT;
                end else begin
                    if ($signed(w_v) > $signed(w_vlim)) n_vel = w_vlim[W_VAL-1:0];
                    else if ($signed(w_v) < -$signed(w_vlim))
                        n_vel = (~w_vlim[W_VAL-1:0]) + 1'b1;
                    else n_vel = w_v[W_VAL-1:0];
                    n_acc = w_apos ? {1'b0, i_cfg.accel} :
                            w_aneg ? (~{1'b0, i_cfg.accel} + 1'b1) : '0;
                    n_state = ST_STEP;
                end
            end
            ST_STEP: n_state = ST_MUL2;
            ST_MUL2: begin
                if (w_d0) n_state = ST_LAND;
            end
            ST_LAND: begin
                if (r_dist <= w_smag) begin
                    n_pos = r_goal;
                    n_vel = '0;
                    n_acc = '0;
                end else if ($signed(w_p) > $signed(w_pmax)) n_pos = w_pmax[W_VAL-1:0];
                else if ($signed(w_p) < $signed(w_pmin)) n_pos = w_pmin[W_VAL-1:0];
                else n_pos = w_p[W_VAL-1:0];
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_seeded <= 1'b0;
            r_pos    <= '0;
            r_vel    <= '0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
            r_pos    <= n_pos;
            r_vel    <= n_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;  r_goal <= n_goal;  r_dist <= n_dist;
        r_speed <= n_speed;  r_dt <= n_dt;  r_dpos <= n_dpos;  r_dneg <= n_dneg;
    end

    assign o_res.pos = r_pos;
    assign o_res.vel = r_vel;
    assign o_res.acc = r_acc;
endmodule

// ----- design/trapezoidal_trajectory_step_top.sv -----
// Top level of the trapezoidal trajectory step block: stream ports and registers.
//
// One input transfer on the slave stream is one control tick: goal position,
// time step and measured position and velocity in tdata, the restart flag in
// tuser. Each tick gives one result transfer on the master stream holding the
// new position, velocity and applied acceleration, all signed Q16.16.
// A tick runs two passes of the bit-serial multipliers (squared speed, braking
// product and velocity change in parallel, then the position step) between
// sequencing states; with a zero acceleration limit the result skips them.
// A new tick is taken once the previous one has been handed to the output
// register, so a result may wait there while the next tick is computing.
// When the receiver stalls, the finished result waits in the sequencer and
// input ready stays low until the output register is free.
// Reset clears the profile state, marks it unseeded, and sets the speed limit
// to 1.0 and the acceleration limit to zero. Configuration writes take effect
// at once and should only be made while the block is idle.
`timescale 1ns / 1ps
`include "trapezoidal_trajectory_step_top_defines.svh"
module trapezoidal_trajectory_step_top
    import rtts_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // goal_position, step_time, measured_position, measured_velocity
    input  logic [119:0] i_s_tdata,
    // restart
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // profile_position, profile_velocity, profile_accel
    output logic [95:0]  o_m_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [30:0]  i_cfg_wdata
);
    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_res;
    t_result r_out;
    logic    r_m_valid;
    logic    w_idle, w_res_valid, w_res_ready, w_start;

    assign w_item.goal    = i_s_tdata[31:0];
    assign w_item.dt      = i_s_tdata[55:32];
    assign w_item.mpos    = i_s_tdata[87:56];
    assign w_item.mvel    = i_s_tdata[119:88];
    assign w_item.restart = i_s_tuser[0];

    assign o_s_tready  = w_idle;
    assign w_start     = i_s_tvalid && w_idle;
    assign w_res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed <= 31'd65536;
            r_cfg.accel <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SPEED: r_cfg.speed <= i_cfg_wdata;
                CFG_ACCEL: r_cfg.accel <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rtts_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_start(w_start),
        .i_item(w_item), .o_idle(w_idle), .o_res_valid(w_res_valid),
        .i_res_ready(w_res_ready), .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) r_out <= w_res;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_out.acc, r_out.vel, r_out.pos};

    `RTTS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, w_start, !o_s_tready)
    `RTTS_ASSERT_NOW(a_snap_zero_vel, i_clk, i_rst_n,
        w_res_valid && (r_cfg.accel == '0), (w_res.vel == '0) && (w_res.acc == '0))
    `RTTS_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_res_valid && w_res_ready, o_m_tvalid)
endmodule

// ----- dv/tb_trapezoidal_trajectory_step_top.sv -----
// Self-checking testbench for the trapezoidal trajectory step block.
`timescale 1ns / 1ps
module tb_trapezoidal_trajectory_step_top;
    import rtts_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [119:0] i_s_tdata;   // goal_position, step_time, measured_position, measured_velocity
    logic [0:0]   i_s_tuser;   // restart
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [95:0]  o_m_tdata;   // profile_position, profile_velocity, profile_accel
    logic         i_cfg_we;
    logic         i_cfg_addr;
    logic [30:0]  i_cfg_wdata;

    trapezoidal_trajectory_step_top uut (.*);

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state and register copies.
    longint          prof_pos;
    longint          prof_vel;
    bit              prof_seeded;
    longint unsigned lim_speed;
    longint unsigned lim_accel;

    t_item   tick_queue[$];
    t_result want_queue[$];
    t_item   tick_on_bus;

    int send_gap_pct;
    int recv_gap_pct;
    bit hold_go;
    bit hold_done;
    int hold_cnt;

    int n_fail;
    int n_checked;
    int n_ticks;
    int n_restarts;
    int n_landed;
    int n_cfg;

    function automatic longint unsigned abs_u(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Signed value times dt over 2^24, magnitude truncated.
    function automatic longint times_dt(longint v, longint unsigned dt);
        longint m;
        m = longint'((abs_u(v) * dt) >> 24);
        return v < 0 ? -m : m;
    endfunction

    function automatic t_result profile_tick(t_item it);
        t_result         r;
        longint          goal;
        longint unsigned dt;
        longint          accel;
        longint          err;
        longint          dir;
        longint unsigned gap;
        longint unsigned speed;
        longint unsigned stop;
        longint          along;
        longint          vmax;
        longint          v;
        longint          step;
        longint          p;
        goal  = longint'($signed(it.goal));
        dt    = it.dt;
        accel = 0;
        if (dt == 0 || dt > DT_MAX) dt = DT_DEFAULT;
        if (!prof_seeded || it.restart) begin
            prof_pos    = longint'($signed(it.mpos));
            prof_vel    = longint'($signed(it.mvel));
            prof_seeded = 1'b1;
        end
        if (lim_accel == 0) begin
            prof_pos = goal;
            prof_vel = 0;
        end else begin
            err   = goal - prof_pos;
            dir   = err > 0 ? 1 : (err < 0 ? -1 : 0);
            gap   = abs_u(err);
            speed = abs_u(prof_vel);
            along = prof_vel * dir;
            vmax  = longint'(lim_speed);
            if (gap == 0 && (speed << 24) < lim_accel * dt) begin
                prof_pos = goal;
                prof_vel = 0;
            end else begin
                stop = (speed * speed) / (2 * lim_accel);
                if (along < 0) accel = dir * longint'(lim_accel);
                else if (stop >= gap) accel = -dir * longint'(lim_accel);
                else if (longint'(speed) < vmax) accel = dir * longint'(lim_accel);
                else accel = 0;
                v = prof_vel + times_dt(accel, dt);
                if (v > vmax) v = vmax;
                if (v < -vmax) v = -vmax;
                prof_vel = v;
                step = times_dt(v, dt);
                if (gap <= abs_u(step)) begin
                    prof_pos = goal;
                    prof_vel = 0;
                    accel    = 0;
                end else begin
                    p = prof_pos + step;
                    if (p > 64'sd2147483647) p = 64'sd2147483647;
                    if (p < -64'sd2147483648) p = -64'sd2147483648;
                    prof_pos = p;
                end
            end
        end
        r.pos = prof_pos[31:0];
        r.vel = prof_vel[31:0];
        r.acc = accel[31:0];
        return r;
    endfunction

    // Driver: the predictor runs on each accepted transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                want_queue.push_back(profile_tick(tick_on_bus));
                n_ticks++;
                if (tick_on_bus.restart) n_restarts++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (tick_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                    tick_on_bus = tick_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= tick_on_bus[119:0];
                    i_s_tuser  <= tick_on_bus.restart;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver with random stalls and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= 0;
            hold_done  <= 1'b0;
        end else if (hold_go && !hold_done) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= hold_cnt + 1;
            if (hold_cnt == 600) hold_done <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (want_queue.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result transfer: %h", got);
            end else begin
                want = want_queue.pop_front();
                n_checked++;
                if (want.acc == 0 && want.vel == 0) n_landed++;
                if (got !== want) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch pos %h/%h vel %h/%h acc %h/%h (exp/act)",
                                 want.pos, got.pos, want.vel, got.vel, want.acc, got.acc);
                end
            end
        end
    end

    task automatic write_reg(logic addr, longint unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value[30:0];
        if (addr == CFG_SPEED) lim_speed = value[30:0];
        else lim_accel = value[30:0];
        n_cfg++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tick_queue.size() > 0 || i_s_tvalid || want_queue.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic add_tick(logic [31:0] goal, logic [23:0] dt, logic [31:0] mpos,
                            logic [31:0] mvel, logic restart);
        t_item it;
        it.goal    = goal;
        it.dt      = dt;
        it.mpos    = mpos;
        it.mvel    = mvel;
        it.restart = restart;
        tick_queue.push_back(it);
    endtask

    function automatic logic [23:0] pick_dt();
        case ($urandom_range(9))
            0:       return 24'd0;
            1:       return 24'($urandom_range(24'hFFFFFF, 24'h800001));
            2:       return 24'($urandom);
            3:       return DT_MAX;
            default: return 24'($urandom_range(8388608, 1));
        endcase
    endfunction

    // One move: seed, then a run of ticks toward a fixed goal.
    task automatic add_move(int len);
        logic [31:0] start;
        logic [31:0] goal;
        logic [31:0] mvel;
        start = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h00400000, 0) - 32'h00200000;
        goal  = $urandom_range(3) == 0 ? $urandom : start + $urandom_range(32'h00800000, 0)
                - 32'h00400000;
        mvel  = $urandom_range(2) == 0 ? $urandom : $urandom_range(32'h00080000, 0) - 32'h00040000;
        add_tick(goal, pick_dt(), start, mvel, 1'b1);
        for (int k = 1; k < len; k++)
            add_tick(goal, $urandom_range(4) == 0 ? pick_dt() : 24'd262144,
                     $urandom, $urandom, $urandom_range(19) == 0);
    endtask

    task automatic random_phase(int n_items);
        int added;
        int len;
        added = 0;
        if ($urandom_range(5) == 0) write_reg(CFG_SPEED, $urandom_range(32'h7FFFFFFF, 0));
        else write_reg(CFG_SPEED, $urandom_range(32'h00400000, 32'h00004000));
        if ($urandom_range(7) == 0) write_reg(CFG_ACCEL, 0);
        else write_reg(CFG_ACCEL, $urandom_range(32'h00400000, 32'h00004000));
        while (added < n_items) begin
            if ($urandom_range(9) == 0) begin
                add_tick($urandom, 24'($urandom), $urandom, $urandom,
                         1'($urandom_range(1)));
                added++;
            end else begin
                len = $urandom_range(40, 8);
                add_move(len);
                added += len;
            end
        end
        wait_drained();
    endtask

    initial begin
        prof_pos = 0; prof_vel = 0; prof_seeded = 0;
        lim_speed = 65536; lim_accel = 0;
        n_fail = 0; n_checked = 0; n_ticks = 0; n_restarts = 0; n_landed = 0; n_cfg = 0;
        send_gap_pct = 14; recv_gap_pct = 79;
        hold_go = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = '0;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_addr = CFG_SPEED; i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: profiling disabled, output snaps to the goal.
        add_tick(32'h7FFFFFFF, 24'd0, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        add_tick(32'h80000000, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1);
        add_tick(32'h00010000, DT_MAX, 32'h0, 32'h0, 1'b0);
        wait_drained();

        write_reg(CFG_ACCEL, 32'h00010000);
        add_tick(32'h00050000, 24'd262144, 32'h0, 32'h0, 1'b1);
        add_tick(32'h00050000, 24'd0, 32'h0, 32'h0, 1'b0);
        add_tick(32'h00050000, DT_MAX + 24'd1, 32'h0, 32'h0, 1'b0);
        add_tick(32'h00050000, DT_MAX, 32'h0, 32'h0, 1'b0);
        // At the goal and almost stopped, then at the goal while moving.
        add_tick(32'h00020000, 24'd262144, 32'h00020000, 32'h00000010, 1'b1);
        add_tick(32'h00020000, 24'd262144, 32'h00020000, 32'h00030000, 1'b1);
        // Moving away from the goal, and a short hop that brakes to a stop before the goal.
        add_tick(32'hFFFF0000, 24'd262144, 32'h00010000, 32'h00008000, 1'b1);
        add_tick(32'h00000100, DT_MAX, 32'h0, 32'h00008000, 1'b1);
        wait_drained();

        // Extreme limits: position saturation while heading away.
        write_reg(CFG_SPEED, 32'h7FFFFFFF);
        write_reg(CFG_ACCEL, 32'h7FFFFFFF);
        add_tick(32'h80000000, DT_MAX, 32'h7FFF0000, 32'h7FFFFFFF, 1'b1);
        add_tick(32'h7FFFFFFF, DT_MAX, 32'h80010000, 32'h80000000, 1'b1);
        add_tick(32'h7FFFFFFF, 24'hFFFFFF, 32'h80000000, 32'h0, 1'b1);
        wait_drained();
        write_reg(CFG_SPEED, 0);
        write_reg(CFG_ACCEL, 1);
        add_tick(32'h00100000, 24'd1, 32'h0, 32'h7FFFFFFF, 1'b1);
        add_tick(32'h00100000, DT_MAX, 32'h0, 32'h80000000, 1'b1);
        wait_drained();
        write_reg(CFG_SPEED, 1);
        add_tick(32'h80000000, 24'd1, 32'h7FFFFFFF, 32'h1, 1'b1);
        wait_drained();

        random_phase(80);
        random_phase(80);
        send_gap_pct = 79; recv_gap_pct = 14;
        random_phase(80);
        // Long receiver hold-off while ticks keep coming.
        write_reg(CFG_SPEED, 32'h00100000);
        write_reg(CFG_ACCEL, 32'h00080000);
        send_gap_pct = 0;
        add_move(30);
        hold_go = 1'b1;
        wait_drained();
        send_gap_pct = 79;
        random_phase(70);
        send_gap_pct = 0; recv_gap_pct = 0;
        random_phase(80);
        random_phase(80);

        $display("Ran %0d ticks (%0d reseeds) over %0d register writes, checked %0d results.",
                 n_ticks, n_restarts, n_cfg, n_checked);
        $display("%0d results ended at rest, with sender and receiver stalls in both orders.",
                 n_landed);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout");
        $display("TB_ERROR");
        $finish;
    end
endmodule
